// ===== design/c3z_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the 3x3 zero-padded convolution
// no dependencies
package c3z_pkg;

   localparam int PIX_BITS       = 8;
   localparam int NB_TAPS        = 9;
   localparam int FW_BITS        = 11;
   localparam int FH_BITS        = 13;
   localparam int ROW_BITS       = 13;
   localparam int COEF_SLOT      = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;

   localparam logic [FH_BITS-1:0]       MAX_HEIGHT   = 13'd4096;
   localparam logic [FW_BITS-1:0]       WIDTH_RESET  = 11'd1024;
   localparam logic [FH_BITS-1:0]       HEIGHT_RESET = 13'd1024;
   localparam logic [CSR_DATA_BITS-1:0] COEF_TOP_RESET    = 48'h0400_0800_0400;
   localparam logic [CSR_DATA_BITS-1:0] COEF_MIDDLE_RESET = 48'h0800_1000_0800;
   localparam logic [CSR_DATA_BITS-1:0] COEF_BOTTOM_RESET = 48'h0400_0800_0400;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_COEF_TOP,
      CSR_COEF_MIDDLE,
      CSR_COEF_BOTTOM
   } csr_index_type;

   typedef logic [PIX_BITS-1:0] pix_type;
   typedef pix_type [NB_TAPS-1:0] nbhd_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tok_ctrl_type;

endpackage

// ===== design/c3z_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces: pixel requests, filtered responses, register writes
// depends on c3z_pkg
interface c3z_req_if;
   logic                         valid;
   logic                         ready;
   logic [c3z_pkg::PIX_BITS-1:0] pixel_in;
   logic                         flush;

   modport source (output valid, output pixel_in, output flush, input ready);
   modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

interface c3z_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [c3z_pkg::PIX_BITS-1:0] pixel_out;
   logic                         frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface c3z_csr_if;
   logic                               valid;
   logic                               ready;
   logic [c3z_pkg::CSR_INDEX_BITS-1:0] reg_index;
   logic [c3z_pkg::CSR_DATA_BITS-1:0]  wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/c3z_front.sv =====
`timescale 1ns / 1ps
// raster front end: position counters, two line stores, 3x3 window, edge masking
// depends on c3z_pkg and c3z_if
module c3z_front #(
   parameter int MAX_WIDTH = 1024,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int EW = (WW > c3z_pkg::FW_BITS) ? WW : c3z_pkg::FW_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   c3z_req_if.sink                       req,
   input  logic [EW-1:0]                 eff_width,
   input  logic [c3z_pkg::FH_BITS-1:0]   eff_height,
   output c3z_pkg::tok_ctrl_type         tok_ctrl,
   output c3z_pkg::nbhd_type             tok_pix,
   input  logic                          down_ready
);

   localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int XW  = EW + 1;
   localparam int RW  = c3z_pkg::ROW_BITS;
   localparam int RXW = RW + 1;

   logic [c3z_pkg::PIX_BITS-1:0] upper_mem [MAX_WIDTH];
   logic [c3z_pkg::PIX_BITS-1:0] middle_mem [MAX_WIDTH];
   logic [c3z_pkg::PIX_BITS-1:0] upper_q_ff, middle_q_ff;
   logic                         byp_ff, byp_in;
   logic [c3z_pkg::PIX_BITS-1:0] byp_top_ff, byp_top_in, byp_mid_ff, byp_mid_in;

   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;

   c3z_pkg::nbhd_type     win_ff, win_in, win_sh, nb;
   c3z_pkg::tok_ctrl_type tok_ctrl_ff, tok_ctrl_in;
   c3z_pkg::nbhd_type     tok_pix_ff, tok_pix_in;

   logic                         acc, emit, last, col_end, row_end;
   logic [c3z_pkg::PIX_BITS-1:0] x, top_px, mid_px;
   logic [XW-1:0]                in_col_w, out_col_w, w_w;
   logic [RXW-1:0]               out_row_w, h_w;

   assign req.ready = !tok_ctrl_ff.valid || down_ready;
   assign acc       = req.valid && req.ready;
   assign x         = req.flush ? '0 : req.pixel_in;
   assign top_px    = byp_ff ? byp_top_ff : upper_q_ff;
   assign mid_px    = byp_ff ? byp_mid_ff : middle_q_ff;

   assign in_col_w  = XW'(in_col_ff);
   assign out_col_w = XW'(out_col_ff);
   assign w_w       = XW'(eff_width);
   assign out_row_w = RXW'(out_row_ff);
   assign h_w       = RXW'(eff_height);

   assign emit    = (in_row_ff >= RW'(2)) || ((in_row_ff == RW'(1)) && (in_col_ff != '0));
   assign col_end = (out_col_w + XW'(1)) >= w_w;
   assign row_end = (out_row_w + RXW'(1)) >= h_w;
   assign last    = col_end && row_end;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_sh[r*3]   = win_ff[r*3+1];
         win_sh[r*3+1] = win_ff[r*3+2];
      end
      win_sh[2] = top_px;
      win_sh[5] = mid_px;
      win_sh[8] = x;
      win_in = acc ? win_sh : win_ff;

      // at column zero the window is centered on the previous row's last pixel
      if (in_col_ff == '0) begin
         for (int r = 0; r < 3; r++) begin
            nb[r*3]   = win_ff[r*3+1];
            nb[r*3+1] = win_ff[r*3+2];
            nb[r*3+2] = '0;
         end
      end else begin
         nb = win_sh;
      end
      for (int k = 0; k < 3; k++) begin
         if (out_row_ff == '0) nb[k] = '0;
         if (row_end) nb[6+k] = '0;
         if (out_col_ff == '0) nb[k*3] = '0;
         if (col_end) nb[k*3+2] = '0;
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (acc) begin
         if (emit && last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (emit) begin
               if (col_end) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + RW'(1);
               end else begin
                  out_col_in = CW'(out_col_w + XW'(1));
               end
            end
            if ((in_col_w + XW'(1)) >= w_w) begin
               in_col_in = '0;
               in_row_in = in_row_ff + RW'(1);
            end else begin
               in_col_in = CW'(in_col_w + XW'(1));
            end
         end
      end
   end

   assign byp_in     = acc && (in_col_in == in_col_ff);
   assign byp_top_in = mid_px;
   assign byp_mid_in = x;

   always_comb begin
      tok_ctrl_in = tok_ctrl_ff;
      tok_pix_in  = tok_pix_ff;
      if (acc) begin
         tok_ctrl_in.valid = emit;
         tok_ctrl_in.last  = last;
         tok_pix_in        = nb;
      end else if (down_ready) begin
         tok_ctrl_in.valid = 1'b0;
      end
   end

   // line stores
   always_ff @(posedge clock) begin
      if (acc) begin
         upper_mem[in_col_ff]  <= mid_px;
         middle_mem[in_col_ff] <= x;
      end
      upper_q_ff  <= upper_mem[in_col_in];
      middle_q_ff <= middle_mem[in_col_in];
   end

   always_ff @(posedge clock) begin
      byp_top_ff <= byp_top_in;
      byp_mid_ff <= byp_mid_in;
      tok_pix_ff <= tok_pix_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff      <= 1'b0;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         win_ff      <= '0;
         tok_ctrl_ff <= '0;
      end else begin
         byp_ff      <= byp_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         win_ff      <= win_in;
         tok_ctrl_ff <= tok_ctrl_in;
      end
   end

   assign tok_ctrl = tok_ctrl_ff;
   assign tok_pix  = tok_pix_ff;

`ifndef SYNTHESIS
   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (acc && emit && last) |=> (in_col_ff == '0 && in_row_ff == '0 && out_row_ff == '0))
      else $error("counters not cleared at frame end");
   a_bypass_same_col: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> $stable(in_col_ff))
      else $error("line store bypass with moved column");
   a_token_hold: assert property (@(posedge clock) disable iff (reset)
      (tok_ctrl_ff.valid && !down_ready) |=> (tok_ctrl_ff.valid && $stable(tok_pix_ff)))
      else $error("stalled window token changed");
`endif

endmodule

// ===== design/c3z_mac_cell.sv =====
`timescale 1ns / 1ps
// one multiply-accumulate stage of the tap chain, consumes the lowest pixel of the token
// depends on c3z_pkg
module c3z_mac_cell #(
   parameter int COEF_BITS = 16,
   parameter int ACC_W     = 29
) (
   input  logic                          clock,
   input  logic                          reset,
   input  c3z_pkg::tok_ctrl_type         in_ctrl,
   input  c3z_pkg::nbhd_type             in_pix,
   input  logic signed [ACC_W-1:0]       in_acc,
   output logic                          in_ready,
   input  logic signed [COEF_BITS-1:0]   coef,
   output c3z_pkg::tok_ctrl_type         out_ctrl,
   output c3z_pkg::nbhd_type             out_pix,
   output logic signed [ACC_W-1:0]       out_acc,
   input  logic                          out_ready
);

   c3z_pkg::tok_ctrl_type    ctrl_ff, ctrl_in;
   c3z_pkg::nbhd_type        pix_ff, pix_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [COEF_BITS+8:0] prod;
   logic                     load;

   assign prod     = $signed({1'b0, in_pix[0]}) * coef;
   assign in_ready = !ctrl_ff.valid || out_ready;
   assign load     = in_ctrl.valid && in_ready;

   always_comb begin
      ctrl_in.valid = in_ready ? in_ctrl.valid : ctrl_ff.valid;
      ctrl_in.last  = load ? in_ctrl.last : ctrl_ff.last;
      acc_in        = load ? (in_acc + ACC_W'(prod)) : acc_ff;
      pix_in        = load ? {c3z_pkg::PIX_BITS'(0), in_pix[c3z_pkg::NB_TAPS-1:1]} : pix_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      pix_ff <= pix_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   assign out_ctrl = ctrl_ff;
   assign out_pix  = pix_ff;
   assign out_acc  = acc_ff;

`ifndef SYNTHESIS
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> out_ctrl.valid)
      else $error("accepted token lost in tap stage");
`endif

endmodule

// ===== design/conv3x3_zero_padded.sv =====
`timescale 1ns / 1ps
// 3x3 zero-padded convolution of one raster plane, top level
// depends on c3z_pkg, c3z_if, c3z_front, c3z_mac_cell
//
// usage:
//   req_chan carries one raster pixel per transaction, or a flush tick (flush = 1)
//   csr_chan writes frame_width, frame_height and the three coefficient rows;
//     write only while no transaction is in flight
//   rsp_chan returns filtered pixels, frame_last on the last pixel of a frame
// the first frame_width+1 transactions of a frame give no response; after the
//   last pixel, frame_width+1 flush transactions drain the final row
// throughput: one transaction per clock unless rsp_chan stalls, set by the line
//   store access (with write-to-read bypass) and the nine-stage multiply chain
// pipeline: a request transaction that releases a pixel passes to its response
//   through the window token register (loaded at the accepting edge), the nine
//   tap stages and the rounding register
// a stalled receiver holds the response; requests keep being taken until the
//   pipeline stages are full, then req_chan.ready drops
// reset: counters, window, valid bits, settings to defaults; line stores are not
//   cleared, entries not yet written in a frame are masked as padding
module conv3x3_zero_padded #(
   parameter int MAX_WIDTH = 1024,
   parameter int COEF_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   c3z_req_if.sink    req_chan,
   c3z_rsp_if.source  rsp_chan,
   c3z_csr_if.sink    csr_chan
);

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int EW    = (WW > c3z_pkg::FW_BITS) ? WW : c3z_pkg::FW_BITS;
   localparam int ACC_W = COEF_BITS + 13;
   localparam int FRAC  = COEF_BITS - 2;
   localparam int NT    = c3z_pkg::NB_TAPS;
   localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(1) << (FRAC - 1);

   logic [c3z_pkg::FW_BITS-1:0]       frame_width_ff;
   logic [c3z_pkg::FH_BITS-1:0]       frame_height_ff;
   logic [c3z_pkg::CSR_DATA_BITS-1:0] coef_row_ff [3];

   logic [EW-1:0]               eff_width;
   logic [c3z_pkg::FH_BITS-1:0] eff_height;

   c3z_pkg::tok_ctrl_type     ctrl_chain [NT+1];
   c3z_pkg::nbhd_type         pix_chain [NT+1];
   logic signed [ACC_W-1:0]   acc_chain [NT+1];
   logic                      rdy_chain [NT+1];
   logic signed [COEF_BITS-1:0] coef_tap [NT];

   logic                         rsp_v_ff, rsp_v_in, rsp_last_ff, rsp_last_in;
   logic [c3z_pkg::PIX_BITS-1:0] rsp_pix_ff, rsp_pix_in, sat_pix;
   logic signed [ACC_W:0]        rsum, rshift;

   // configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= c3z_pkg::WIDTH_RESET;
         frame_height_ff <= c3z_pkg::HEIGHT_RESET;
         coef_row_ff[0]  <= c3z_pkg::COEF_TOP_RESET;
         coef_row_ff[1]  <= c3z_pkg::COEF_MIDDLE_RESET;
         coef_row_ff[2]  <= c3z_pkg::COEF_BOTTOM_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.reg_index)
            c3z_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_chan.wdata[c3z_pkg::FW_BITS-1:0];
            end
            c3z_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_chan.wdata[c3z_pkg::FH_BITS-1:0];
            end
            c3z_pkg::CSR_COEF_TOP: begin
               coef_row_ff[0] <= csr_chan.wdata;
            end
            c3z_pkg::CSR_COEF_MIDDLE: begin
               coef_row_ff[1] <= csr_chan.wdata;
            end
            c3z_pkg::CSR_COEF_BOTTOM: begin
               coef_row_ff[2] <= csr_chan.wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         eff_width = EW'(1);
      end else if (EW'(frame_width_ff) > EW'(MAX_WIDTH)) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = EW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         eff_height = c3z_pkg::FH_BITS'(1);
      end else if (frame_height_ff > c3z_pkg::MAX_HEIGHT) begin
         eff_height = c3z_pkg::MAX_HEIGHT;
      end else begin
         eff_height = frame_height_ff;
      end
   end

   c3z_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .tok_ctrl   (ctrl_chain[0]),
      .tok_pix    (pix_chain[0]),
      .down_ready (rdy_chain[0])
   );

   assign acc_chain[0] = '0;

   for (genvar k = 0; k < NT; k++) begin : g_tap
      localparam int R = k / 3;
      localparam int C = k % 3;

      assign coef_tap[k] = coef_row_ff[R][C*c3z_pkg::COEF_SLOT +: COEF_BITS];

      c3z_mac_cell #(
         .COEF_BITS (COEF_BITS),
         .ACC_W     (ACC_W)
      ) u_tap (
         .clock     (clock),
         .reset     (reset),
         .in_ctrl   (ctrl_chain[k]),
         .in_pix    (pix_chain[k]),
         .in_acc    (acc_chain[k]),
         .in_ready  (rdy_chain[k]),
         .coef      (coef_tap[k]),
         .out_ctrl  (ctrl_chain[k+1]),
         .out_pix   (pix_chain[k+1]),
         .out_acc   (acc_chain[k+1]),
         .out_ready (rdy_chain[k+1])
      );
   end

   // round half up and saturate to 0..255
   assign rsum    = (ACC_W+1)'(acc_chain[NT]) + HALF;
   assign rshift  = rsum >>> FRAC;
   assign sat_pix = rsum[ACC_W] ? '0 :
                    (rshift > (ACC_W+1)'(255)) ? 8'hff : rshift[c3z_pkg::PIX_BITS-1:0];

   assign rdy_chain[NT] = !rsp_v_ff || rsp_chan.ready;

   always_comb begin
      rsp_v_in    = rdy_chain[NT] ? ctrl_chain[NT].valid : rsp_v_ff;
      rsp_pix_in  = rsp_pix_ff;
      rsp_last_in = rsp_last_ff;
      if (rdy_chain[NT] && ctrl_chain[NT].valid) begin
         rsp_pix_in  = sat_pix;
         rsp_last_in = ctrl_chain[NT].last;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
   end

   assign rsp_chan.valid      = rsp_v_ff;
   assign rsp_chan.pixel_out  = rsp_pix_ff;
   assign rsp_chan.frame_last = rsp_last_ff;

endmodule

// ===== tb/tb_conv3x3_zero_padded.sv =====
`timescale 1ns / 1ps
// self-checking testbench of conv3x3_zero_padded: directed and random raster frames
// are checked against a scoreboard class that predicts every filtered pixel
// depends on c3z_pkg, c3z_if and the conv3x3_zero_padded design
module tb_conv3x3_zero_padded;

   localparam int     MAX_WIDTH     = 1024;
   localparam int     COEF_BITS     = 16;
   localparam int     FRAC_BITS     = COEF_BITS - 2;
   localparam int     HOLD_CYCLES   = 300;
   localparam int     DRAIN_PAUSE   = 16;
   localparam int     RANDOM_TARGET = 450;
   localparam int     TAIL_ITEMS    = 120;
   localparam int     MAX_REPORTS   = 20;
   localparam longint LIMIT_NS      = 40_000_000;

   // bit 8 is the flush flag
   localparam logic [8:0] DIRECTED_3X3 [13] = '{
      9'h0FF, 9'h000, 9'h0FF,
      9'h1AB, 9'h0FF, 9'h001,
      9'h0FE, 9'h000, 9'h0FF,
      9'h100, 9'h0C8, 9'h155, 9'h100
   };

   typedef struct packed {
      logic             frame_last;
      c3z_pkg::pix_type pixel;
   } filtered_pix_type;

   class filter_scoreboard;
      logic [c3z_pkg::FW_BITS-1:0]       width_reg;
      logic [c3z_pkg::FH_BITS-1:0]       height_reg;
      logic [c3z_pkg::CSR_DATA_BITS-1:0] coef_reg [3];
      c3z_pkg::pix_type                  upper_line [MAX_WIDTH];
      c3z_pkg::pix_type                  middle_line [MAX_WIDTH];
      c3z_pkg::pix_type                  win [9];
      int unsigned                       in_row, in_col, out_row, out_col;
      filtered_pix_type                  expected [$];
      int unsigned                       errors, item_count, flush_count, checked, frames;
      int unsigned                       clipped_high, clipped_low;

      function new();
         width_reg   = c3z_pkg::WIDTH_RESET;
         height_reg  = c3z_pkg::HEIGHT_RESET;
         coef_reg[0] = c3z_pkg::COEF_TOP_RESET;
         coef_reg[1] = c3z_pkg::COEF_MIDDLE_RESET;
         coef_reg[2] = c3z_pkg::COEF_BOTTOM_RESET;
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         in_row  = 0;
         in_col  = 0;
         out_row = 0;
         out_col = 0;
      endfunction

      function void write_register(c3z_pkg::csr_index_type idx,
                                   logic [c3z_pkg::CSR_DATA_BITS-1:0] value);
         case (idx)
            c3z_pkg::CSR_FRAME_WIDTH:  width_reg   = value[c3z_pkg::FW_BITS-1:0];
            c3z_pkg::CSR_FRAME_HEIGHT: height_reg  = value[c3z_pkg::FH_BITS-1:0];
            c3z_pkg::CSR_COEF_TOP:     coef_reg[0] = value;
            c3z_pkg::CSR_COEF_MIDDLE:  coef_reg[1] = value;
            c3z_pkg::CSR_COEF_BOTTOM:  coef_reg[2] = value;
            default: ;
         endcase
      endfunction

      function int unsigned eff_width();
         if (width_reg == '0) return 1;
         if (32'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
         return 32'(width_reg);
      endfunction

      function int unsigned eff_height();
         if (height_reg == '0) return 1;
         if (height_reg > c3z_pkg::MAX_HEIGHT) return 32'(c3z_pkg::MAX_HEIGHT);
         return 32'(height_reg);
      endfunction

      function logic signed [COEF_BITS-1:0] coef(int unsigned r, int unsigned k);
         return coef_reg[r][c3z_pkg::COEF_SLOT*k +: COEF_BITS];
      endfunction

      function int unsigned pending();
         return expected.size();
      endfunction

      // advances the raster position and queues the filtered pixel it releases
      function void accept_pixel(c3z_pkg::pix_type pixel_in, logic flush);
         int unsigned      w, h, col;
         c3z_pkg::pix_type x, top, mid;
         c3z_pkg::pix_type prior [9];
         c3z_pkg::pix_type tap [9];
         longint           acc, level;
         logic             last;
         filtered_pix_type item;
         item_count++;
         if (flush) flush_count++;
         w   = eff_width();
         h   = eff_height();
         col = in_col;
         x   = flush ? '0 : pixel_in;
         top = upper_line[col];
         mid = middle_line[col];
         prior = win;
         for (int r = 0; r < 3; r++) begin
            win[3*r]     = win[3*r+1];
            win[3*r+1]   = win[3*r+2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = x;
         upper_line[col]  = mid;
         middle_line[col] = x;

         if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
            for (int r = 0; r < 3; r++) begin
               if (col == 0) begin
                  tap[3*r]   = prior[3*r+1];
                  tap[3*r+1] = prior[3*r+2];
                  tap[3*r+2] = '0;
               end else begin
                  tap[3*r]   = win[3*r];
                  tap[3*r+1] = win[3*r+1];
                  tap[3*r+2] = win[3*r+2];
               end
            end
            // zero padding outside the frame
            for (int k = 0; k < 3; k++) begin
               if (out_row == 0) tap[k] = '0;
               if (out_row + 1 >= h) tap[6+k] = '0;
               if (out_col == 0) tap[3*k] = '0;
               if (out_col + 1 >= w) tap[3*k+2] = '0;
            end
            acc = 0;
            for (int r = 0; r < 3; r++)
               for (int k = 0; k < 3; k++)
                  acc += longint'(tap[3*r+k]) * longint'(coef(r, k));
            acc += longint'(1) <<< (FRAC_BITS - 1);
            if (acc < 0) begin
               level = 0;
               clipped_low++;
            end else begin
               level = acc >>> FRAC_BITS;
            end
            if (level > 255) begin
               level = 255;
               clipped_high++;
            end
            last = (out_row + 1 >= h) && (out_col + 1 >= w);
            item.frame_last = last;
            item.pixel      = level[c3z_pkg::PIX_BITS-1:0];
            expected.push_back(item);
            if (last) begin
               in_row  = 0;
               in_col  = 0;
               out_row = 0;
               out_col = 0;
               return;
            end
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               out_row++;
            end
         end
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, msg);
      endtask

      task check_output(c3z_pkg::pix_type pixel, logic frame_last);
         filtered_pix_type want;
         if (expected.size() == 0) begin
            report($sformatf("response pixel %0d last %0b with nothing expected",
                             pixel, frame_last));
            return;
         end
         want = expected.pop_front();
         checked++;
         if (want.frame_last) frames++;
         if (pixel !== want.pixel)
            report($sformatf("pixel_out %0d, expected %0d (response %0d)",
                             pixel, want.pixel, checked));
         if (frame_last !== want.frame_last)
            report($sformatf("frame_last %0b, expected %0b (response %0d)",
                             frame_last, want.frame_last, checked));
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;

   c3z_req_if req_if ();
   c3z_rsp_if rsp_if ();
   c3z_csr_if csr_if ();

   filter_scoreboard sb = new();

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   bit          hold_request = 1'b0;

   conv3x3_zero_padded #(
      .MAX_WIDTH (MAX_WIDTH),
      .COEF_BITS (COEF_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("timeout with %0d responses outstanding", sb.pending());
      $display("FAIL conv3x3_zero_padded");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.accept_pixel(req_if.pixel_in, req_if.flush);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_output(rsp_if.pixel_out, rsp_if.frame_last);
   end

   // receiver: random stall bursts, and one long hold on request
   initial begin
      rsp_if.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rsp_idle_pct != 0 && $urandom_range(99, 0) < rsp_idle_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic c3z_pkg::pix_type rand_pixel();
      case ($urandom_range(7, 0))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return c3z_pkg::pix_type'($urandom_range(255, 0));
      endcase
   endfunction

   function automatic logic [c3z_pkg::CSR_DATA_BITS-1:0] rand_coef_row();
      logic [c3z_pkg::CSR_DATA_BITS-1:0] row;
      row = c3z_pkg::CSR_DATA_BITS'({$urandom, $urandom});
      case ($urandom_range(3, 0))
         0: ;
         1: row = $urandom_range(1, 0) ? c3z_pkg::COEF_TOP_RESET : c3z_pkg::COEF_MIDDLE_RESET;
         2: for (int k = 0; k < 3; k++)
               row[c3z_pkg::COEF_SLOT*k +: c3z_pkg::COEF_SLOT] =
                  c3z_pkg::COEF_SLOT'($urandom_range(6144, 0) - 2048);
         default:
            for (int k = 0; k < 3; k++)
               case ($urandom_range(3, 0))
                  0:       row[c3z_pkg::COEF_SLOT*k +: c3z_pkg::COEF_SLOT] = 16'h7FFF;
                  1:       row[c3z_pkg::COEF_SLOT*k +: c3z_pkg::COEF_SLOT] = 16'h8000;
                  2:       row[c3z_pkg::COEF_SLOT*k +: c3z_pkg::COEF_SLOT] = 16'h0000;
                  default: row[c3z_pkg::COEF_SLOT*k +: c3z_pkg::COEF_SLOT] = 16'hC000;
               endcase
      endcase
      return row;
   endfunction

   function automatic int unsigned idle_pct();
      case ($urandom_range(2, 0))
         0:       return 0;
         1:       return 8;
         default: return 30;
      endcase
   endfunction

   task automatic write_register(c3z_pkg::csr_index_type idx,
                                 logic [c3z_pkg::CSR_DATA_BITS-1:0] value);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wdata     <= value;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_register(idx, value);
   endtask

   task automatic configure(logic [c3z_pkg::FW_BITS-1:0] w, logic [c3z_pkg::FH_BITS-1:0] h,
                            logic [c3z_pkg::CSR_DATA_BITS-1:0] top,
                            logic [c3z_pkg::CSR_DATA_BITS-1:0] mid,
                            logic [c3z_pkg::CSR_DATA_BITS-1:0] bot);
      write_register(c3z_pkg::CSR_FRAME_WIDTH, c3z_pkg::CSR_DATA_BITS'(w));
      write_register(c3z_pkg::CSR_FRAME_HEIGHT, c3z_pkg::CSR_DATA_BITS'(h));
      write_register(c3z_pkg::CSR_COEF_TOP, top);
      write_register(c3z_pkg::CSR_COEF_MIDDLE, mid);
      write_register(c3z_pkg::CSR_COEF_BOTTOM, bot);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_item(c3z_pkg::pix_type pixel, logic flush);
      if (req_idle_pct != 0 && $urandom_range(99, 0) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(18, 1)) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.pixel_in <= pixel;
      req_if.flush    <= flush;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // frame of pixels or flushes, then drain flushes or surplus pixels for the last row
   task automatic send_frame(int unsigned flush_pct, int unsigned surplus_pct);
      int unsigned w, h;
      w = sb.eff_width();
      h = sb.eff_height();
      for (int unsigned i = 0; i < w * h; i++)
         send_item(rand_pixel(), $urandom_range(99, 0) < flush_pct);
      for (int unsigned i = 0; i < w + 1; i++)
         send_item(rand_pixel(), !($urandom_range(99, 0) < surplus_pct));
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic random_phase(bit with_idle);
      logic [c3z_pkg::FW_BITS-1:0] w;
      logic [c3z_pkg::FH_BITS-1:0] h;
      int unsigned                 frame_total;
      req_idle_pct = with_idle ? idle_pct() : 0;
      rsp_idle_pct = with_idle ? idle_pct() : 0;
      case ($urandom_range(9, 0))
         0:       w = 11'd1;
         1:       w = 11'd2;
         7, 8:    w = c3z_pkg::FW_BITS'($urandom_range(40, 11));
         9:       w = 11'd0;
         default: w = c3z_pkg::FW_BITS'($urandom_range(10, 3));
      endcase
      case ($urandom_range(9, 0))
         0:       h = 13'd1;
         1:       h = 13'd2;
         8:       h = c3z_pkg::FH_BITS'($urandom_range(16, 9));
         9:       h = 13'd0;
         default: h = c3z_pkg::FH_BITS'($urandom_range(8, 3));
      endcase
      configure(w, h, rand_coef_row(), rand_coef_row(), rand_coef_row());
      frame_total = $urandom_range(3, 1);
      repeat (frame_total) begin
         case ($urandom_range(2, 0))
            0:       send_frame($urandom_range(1, 0) ? 0 : 5, 100);
            1:       send_frame($urandom_range(1, 0) ? 0 : 5, 30);
            default: send_frame($urandom_range(1, 0) ? 0 : 5, 0);
         endcase
      end
      settle();
   endtask

   initial begin
      int unsigned tail_end;
      req_if.valid     <= 1'b0;
      req_if.pixel_in  <= '0;
      req_if.flush     <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.reg_index <= c3z_pkg::CSR_FRAME_WIDTH;
      csr_if.wdata     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // saturating coefficients on a 3x3 frame with early flush and surplus pixel
      configure(11'd3, 13'd3, 48'h8000_7FFF_0400, 48'h0800_7FFF_0800, 48'hFFFF_0000_8000);
      foreach (DIRECTED_3X3[i]) send_item(DIRECTED_3X3[i][7:0], DIRECTED_3X3[i][8]);
      settle();

      // zero sizes clamp to a single pixel frame
      configure(11'd0, 13'd0, c3z_pkg::COEF_TOP_RESET, c3z_pkg::COEF_MIDDLE_RESET,
                c3z_pkg::COEF_BOTTOM_RESET);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'h80, 1'b0);
      settle();

      // long receiver hold while the sender streams back to back
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      configure(11'd16, 13'd6, c3z_pkg::COEF_TOP_RESET, c3z_pkg::COEF_MIDDLE_RESET,
                c3z_pkg::COEF_BOTTOM_RESET);
      hold_request = 1'b1;
      send_frame(0, 0);
      settle();

      while (sb.item_count < RANDOM_TARGET) random_phase(1'b1);

      // narrow tall frame and wide flat frame
      req_idle_pct = 5;
      rsp_idle_pct = 5;
      configure(11'd1, 13'd24, rand_coef_row(), rand_coef_row(), rand_coef_row());
      send_frame(5, 30);
      settle();
      configure(11'd64, 13'd1, c3z_pkg::COEF_TOP_RESET, c3z_pkg::COEF_MIDDLE_RESET,
                c3z_pkg::COEF_BOTTOM_RESET);
      send_frame(0, 0);
      settle();

      tail_end = sb.item_count + TAIL_ITEMS;
      while (sb.item_count < tail_end) random_phase(1'b0);

      $display("covered %0d transactions (%0d flush ticks) in %0d frames, widths 1..64",
               sb.item_count, sb.flush_count, sb.frames);
      $display("checked %0d filtered pixels, %0d saturated high, %0d clamped low",
               sb.checked, sb.clipped_high, sb.clipped_low);
      if (sb.errors == 0)
         $display("PASS conv3x3_zero_padded");
      else
         $display("FAIL conv3x3_zero_padded");
      $finish;
   end

endmodule

// ===== sim.f =====
design/c3z_pkg.sv
design/c3z_if.sv
design/c3z_front.sv
design/c3z_mac_cell.sv
design/conv3x3_zero_padded.sv
tb/tb_conv3x3_zero_padded.sv
